// File: rtl/tksl_pkg.sv
// ----------------------------------------------------------------------------
// tksl_pkg: shared types and constants for the top-k sorted score list
// Sizes, command/mode/status codes and the structs that go to the cells.
// ----------------------------------------------------------------------------
package tksl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W       = 5;
  localparam int ECNT_W      = 5;
  localparam int SCORE_W     = 32;
  localparam int TAG_W       = 32;
  localparam int POS_W       = 4;
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [1:0] {
    CMD_ADD          = 2'd0,
    CMD_REMOVE_MATCH = 2'd1,
    CMD_REMOVE_POS   = 2'd2,
    CMD_NOP          = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_SCORE = 2'd0,
    MODE_TAG   = 2'd1,
    MODE_BOTH  = 2'd2,
    MODE_ANY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_BAD_POS  = 2'd3
  } status_t;

  // Broadcast to every cell with the item being processed
  typedef struct packed {
    cmd_t                      cmd;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    mode_t                     mode;
    logic                      full;
    logic                      add_ok;
  } tksl_req_t;

  // Per-slot occupancy decode from the held count
  typedef struct packed {
    logic occupied;
    logic first_free;
    logic last_held;
    logic pos_hit;
  } tksl_slot_t;

endpackage

// File: rtl/tksl_cell.sv
// ----------------------------------------------------------------------------
// tksl_cell: one slot of the sorted list
// Holds one score/tag pair; shifts from its upper or lower neighbor on add
// and remove, or loads the new entry at the insertion point.
// ----------------------------------------------------------------------------
module tksl_cell (
  input  logic                               clk,
  input  logic                               load_en,
  input  tksl_pkg::tksl_req_t                req,
  input  tksl_pkg::tksl_slot_t               slot,
  input  logic                               prev_lt,
  input  logic signed [tksl_pkg::SCORE_W-1:0] prev_score,
  input  logic [tksl_pkg::TAG_W-1:0]          prev_tag,
  input  logic signed [tksl_pkg::SCORE_W-1:0] next_score,
  input  logic [tksl_pkg::TAG_W-1:0]          next_tag,
  input  logic                               hit_in,
  output logic                               lt,
  output logic                               hit_out,
  output logic                               take,
  output logic signed [tksl_pkg::SCORE_W-1:0] score,
  output logic [tksl_pkg::TAG_W-1:0]          tag
);
  import tksl_pkg::*;

  logic in_range;
  logic score_eq;
  logic tag_eq;
  logic match;
  logic hit;

  always_comb begin
    // slot takes part in an add if held, or if it is the slot the list grows into
    in_range = slot.occupied | (slot.first_free & ~req.full);
    // a free slot or the entry about to drop out counts as below the new score
    lt = ~slot.occupied | (slot.last_held & req.full) | (score < req.score);
    score_eq = (score == req.score);
    tag_eq   = (tag == req.tag);
    case (req.mode)
      MODE_SCORE: match = score_eq;
      MODE_TAG:   match = tag_eq;
      MODE_BOTH:  match = score_eq & tag_eq;
      default:    match = 1'b1;
    endcase
    // only the two remove commands take a slot
    hit = slot.occupied & ((req.cmd == CMD_REMOVE_POS) ? slot.pos_hit :
                           ((req.cmd == CMD_REMOVE_MATCH) & match));
    take    = hit & ~hit_in;
    hit_out = hit_in | hit;
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      case (req.cmd)
        CMD_ADD: begin
          if (req.add_ok && in_range) begin
            if (prev_lt) begin
              score <= prev_score;
              tag   <= prev_tag;
            end else if (lt) begin
              score <= req.score;
              tag   <= req.tag;
            end
          end
        end
        CMD_REMOVE_MATCH, CMD_REMOVE_POS: begin
          // close the gap: the taken slot and all below it pull up
          if (take || hit_in) begin
            score <= next_score;
            tag   <= next_tag;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/top_k_sorted_score_list_top.sv
// ----------------------------------------------------------------------------
// top_k_sorted_score_list_top: sorted top-k list of scored, tagged entries
// Chain of slot cells kept in descending score order, with add and remove.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command item: add an
//   entry, remove the first entry matching on score, tag, both or any, remove the entry
//   at a list position, or do nothing. Each item yields exactly one result item
//   on the output channel (out_valid / out_stall): a status code, the removed
//   entry (zero when nothing is removed) and the number of entries held.
//   Every cell compares its own entry with the broadcast request in the same
//   cycle and shifts to or from its neighbor, so the whole list updates
//   together. The result appears in the output register the cycle after
//   acceptance. Throughput is one item per cycle while the receiver does not
//   stall, set by the cell update and the one-deep output register.
//   The first-match search ripples through the cell chain.
//   When the receiver stalls, the result holds and the input stalls too
//   until the result is taken (in_stall follows out_stall while out_valid).
//   cfg_wr_en/cfg_wr_data set the capacity in use (0 acts as 1, values above
//   the built depth act as the depth); write it only while idle.
//   Reset empties the list and sets the capacity to 16. Slot contents are
//   not cleared: only held slots are ever read.
// ----------------------------------------------------------------------------
module top_k_sorted_score_list_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         cmd,
  input  logic signed [tksl_pkg::SCORE_W-1:0] entry_score,
  input  logic [tksl_pkg::TAG_W-1:0]          entry_tag,
  input  logic [1:0]                         match_mode,
  input  logic [tksl_pkg::POS_W-1:0]          position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic signed [tksl_pkg::SCORE_W-1:0] removed_score,
  output logic [tksl_pkg::TAG_W-1:0]          removed_tag,
  output logic [tksl_pkg::ECNT_W-1:0]         entry_count,
  input  logic                               cfg_wr_en,
  input  logic [tksl_pkg::CFG_W-1:0]          cfg_wr_data
);
  import tksl_pkg::*;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  logic                      accept;
  logic [CFG_W-1:0]          capacity;
  logic [CMP_W-1:0]          cap_wide;
  logic [CMP_W-1:0]          live_cap;
  logic [CNT_W-1:0]          held;
  logic [CNT_W-1:0]          held_next;
  logic signed [SCORE_W-1:0] last_score;
  logic                      refused;
  logic                      any_hit;
  logic [1:0]                status_next;
  logic signed [SCORE_W-1:0] rm_score;
  logic [TAG_W-1:0]          rm_tag;
  tksl_req_t                 req;
  tksl_slot_t                slot [MAX_ENTRIES];

  logic signed [SCORE_W-1:0] cell_score [MAX_ENTRIES];
  logic [TAG_W-1:0]          cell_tag   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    cell_lt;
  logic [MAX_ENTRIES-1:0]    cell_hit;
  logic [MAX_ENTRIES-1:0]    cell_take;

  // Hold the input while a finished result still waits
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Clamp capacity to 1..MAX_ENTRIES
  always_comb begin
    cap_wide = CMP_W'(capacity);
    if (capacity == '0) begin
      live_cap = CMP_W'(1);
    end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
      live_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      live_cap = cap_wide;
    end
  end

  // Decode slot occupancy from the held count
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot[i].occupied   = 32'(i) < 32'(held);
      slot[i].first_free = 32'(i) == 32'(held);
      slot[i].last_held  = 32'(i + 1) == 32'(held);
      slot[i].pos_hit    = 32'(i) == 32'(position);
    end
  end

  // Select the last held entry and the removed entry by one-hot OR
  always_comb begin
    last_score = '0;
    rm_score   = '0;
    rm_tag     = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot[i].last_held) begin
        last_score = last_score | cell_score[i];
      end
      if (cell_take[i]) begin
        rm_score = rm_score | cell_score[i];
        rm_tag   = rm_tag | cell_tag[i];
      end
    end
  end

  always_comb begin
    req.cmd    = cmd_t'(cmd);
    req.score  = entry_score;
    req.tag    = entry_tag;
    req.mode   = mode_t'(match_mode);
    req.full   = CMP_W'(held) >= live_cap;
    // a full list refuses a score strictly below its last entry
    refused    = req.full & (last_score > entry_score);
    req.add_ok = ~refused;
  end

  assign any_hit = cell_hit[MAX_ENTRIES-1];

  // Next count and status
  always_comb begin
    held_next   = held;
    status_next = ST_DONE;
    case (req.cmd)
      CMD_ADD: begin
        if (refused) begin
          status_next = ST_REFUSED;
        end else if (!req.full) begin
          held_next = held + CNT_W'(1);
        end
      end
      CMD_REMOVE_MATCH: begin
        if (any_hit) begin
          held_next = held - CNT_W'(1);
        end else begin
          status_next = ST_NO_MATCH;
        end
      end
      CMD_REMOVE_POS: begin
        if (any_hit) begin
          held_next = held - CNT_W'(1);
        end else begin
          status_next = ST_BAD_POS;
        end
      end
      default: begin
      end
    endcase
  end

  // Row of slot cells; cell 0 holds the highest score
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                      p_lt;
    logic signed [SCORE_W-1:0] p_score;
    logic [TAG_W-1:0]          p_tag;
    logic signed [SCORE_W-1:0] n_score;
    logic [TAG_W-1:0]          n_tag;
    logic                      h_in;

    if (g == 0) begin : g_head
      assign p_lt    = 1'b0;
      assign p_score = '0;
      assign p_tag   = '0;
      assign h_in    = 1'b0;
    end else begin : g_mid
      assign p_lt    = cell_lt[g-1];
      assign p_score = cell_score[g-1];
      assign p_tag   = cell_tag[g-1];
      assign h_in    = cell_hit[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_tail
      assign n_score = '0;
      assign n_tag   = '0;
    end else begin : g_body
      assign n_score = cell_score[g+1];
      assign n_tag   = cell_tag[g+1];
    end

    tksl_cell u_cell (
      .clk        (clk),
      .load_en    (accept),
      .req        (req),
      .slot       (slot[g]),
      .prev_lt    (p_lt),
      .prev_score (p_score),
      .prev_tag   (p_tag),
      .next_score (n_score),
      .next_tag   (n_tag),
      .hit_in     (h_in),
      .lt         (cell_lt[g]),
      .hit_out    (cell_hit[g]),
      .take       (cell_take[g]),
      .score      (cell_score[g]),
      .tag        (cell_tag[g])
    );
  end

  // Control state: count, capacity, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (accept) begin
        held      <= held_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_score <= rm_score;
      removed_tag   <= rm_tag;
      entry_count   <= ECNT_W'(held_next);
    end
  end

  // Count never passes the built depth
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= 32'(MAX_ENTRIES))
    else $error("held count exceeds depth");

  // At most one cell is taken by a remove
  a_take_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_take))
    else $error("more than one cell taken");

  // An accepted item always leaves a result
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // Failed remove reports a zero entry
  a_zero_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_MATCH || status == ST_BAD_POS)
      |-> removed_score == '0 && removed_tag == '0)
    else $error("failed remove returned data");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the top-k sorted score list
// Predicts every result from a local copy of the list, checks it field by
// field, and steps through several capacities and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import tksl_pkg::*;

  localparam logic [SCORE_W-1:0] SCORE_LOWEST  = 32'h8000_0000;
  localparam logic [SCORE_W-1:0] SCORE_HIGHEST = 32'h7FFF_FFFF;
  localparam logic [TAG_W-1:0]   TAG_ONES      = 32'hFFFF_FFFF;
  localparam int                 HANG_LIMIT    = 5000;
  localparam int                 ITEMS_PER_SET = 50;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    mode_t                     mode;
    logic [POS_W-1:0]          pos;
  } list_cmd_t;

  typedef struct packed {
    status_t                   status;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic [ECNT_W-1:0]         count;
  } list_reply_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                cmd;
  logic signed [SCORE_W-1:0] entry_score;
  logic [TAG_W-1:0]          entry_tag;
  logic [1:0]                match_mode;
  logic [POS_W-1:0]          position;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic signed [SCORE_W-1:0] removed_score;
  logic [TAG_W-1:0]          removed_tag;
  logic [ECNT_W-1:0]         entry_count;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]          cfg_wr_data = '0;

  // Item on the input port; the payload fields follow it
  list_cmd_t   cur_cmd = '0;
  list_cmd_t   cmd_queue[$];
  list_reply_t reply_queue[$];

  // Shadow copy of the list and its capacity register
  logic signed [SCORE_W-1:0] shadow_score[MAX_ENTRIES];
  logic [TAG_W-1:0]          shadow_tag[MAX_ENTRIES];
  int                        shadow_count = 0;
  logic [CFG_W-1:0]          shadow_cap = CFG_W'(16);

  int  send_gap_pct   = 0;
  int  recv_stall_pct = 0;
  int  mismatch_count = 0;
  int  hung_cycles    = 0;
  bit  in_taken       = 1'b0;

  assign cmd         = cur_cmd.cmd;
  assign entry_score = cur_cmd.score;
  assign entry_tag   = cur_cmd.tag;
  assign match_mode  = cur_cmd.mode;
  assign position    = cur_cmd.pos;

  top_k_sorted_score_list_top i_dut (
    .clk, .rst,
    .in_valid, .in_stall, .cmd, .entry_score, .entry_tag, .match_mode, .position,
    .out_valid, .out_stall, .status, .removed_score, .removed_tag, .entry_count,
    .cfg_wr_en, .cfg_wr_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pull slot idx out of the shadow list, close the gap, report the entry
  function automatic void take_slot(int idx, inout list_reply_t r);
    int k;
    r.score = shadow_score[idx];
    r.tag   = shadow_tag[idx];
    for (k = idx; k + 1 < shadow_count; k++) begin
      shadow_score[k] = shadow_score[k + 1];
      shadow_tag[k]   = shadow_tag[k + 1];
    end
    shadow_score[k] = '0;
    shadow_tag[k]   = '0;
    shadow_count--;
  endfunction

  // Apply one command to the shadow list and return the reply it yields
  function automatic list_reply_t apply_list_cmd(list_cmd_t c);
    list_reply_t               r;
    logic signed [SCORE_W-1:0] s;
    int                        cap;
    int                        i;
    int                        hit_at;
    bit                        hit;
    bit                        ok;
    r      = '0;
    r.status = ST_DONE;
    s      = c.score;
    hit_at = -1;
    case (c.cmd)
      CMD_ADD: begin
        // Clamp the capacity: zero acts as one, above the depth acts as the depth
        if (shadow_cap == 0)
          cap = 1;
        else if (int'(shadow_cap) > MAX_ENTRIES)
          cap = MAX_ENTRIES;
        else
          cap = int'(shadow_cap);
        ok = 1'b1;
        // Full (or over capacity): the new entry must reach the last one
        if (shadow_count >= cap) begin
          if (shadow_score[shadow_count - 1] > s)
            ok = 1'b0;
        end else begin
          shadow_count++;
        end
        if (ok) begin
          // Insert after every entry of equal score
          i = shadow_count - 1;
          while (i > 0 && shadow_score[i - 1] < s) begin
            shadow_score[i] = shadow_score[i - 1];
            shadow_tag[i]   = shadow_tag[i - 1];
            i--;
          end
          shadow_score[i] = s;
          shadow_tag[i]   = c.tag;
        end else begin
          r.status = ST_REFUSED;
        end
      end
      CMD_REMOVE_MATCH: begin
        for (i = 0; i < shadow_count && hit_at < 0; i++) begin
          hit = 1'b1;
          if (c.mode == MODE_SCORE || c.mode == MODE_BOTH)
            hit = hit && (shadow_score[i] == s);
          if (c.mode == MODE_TAG || c.mode == MODE_BOTH)
            hit = hit && (shadow_tag[i] == c.tag);
          if (hit)
            hit_at = i;
        end
        if (hit_at >= 0)
          take_slot(hit_at, r);
        else
          r.status = ST_NO_MATCH;
      end
      CMD_REMOVE_POS: begin
        if (int'(c.pos) < shadow_count)
          take_slot(int'(c.pos), r);
        else
          r.status = ST_BAD_POS;
      end
      default: ;
    endcase
    r.count = ECNT_W'(shadow_count);
    return r;
  endfunction

  function automatic void queue_cmd(cmd_t c, logic [SCORE_W-1:0] s, logic [TAG_W-1:0] t,
                                    mode_t m, logic [POS_W-1:0] p);
    list_cmd_t it;
    it.cmd   = c;
    it.score = s;
    it.tag   = t;
    it.mode  = m;
    it.pos   = p;
    cmd_queue.push_back(it);
  endfunction

  // Draw scores mostly from a few small values so equal scores and matches
  // are common; keep the extremes and full-width values in the mix.
  function automatic logic [SCORE_W-1:0] pick_score();
    case ($urandom_range(9))
      0:       return SCORE_LOWEST;
      1:       return SCORE_HIGHEST;
      2:       return '1;
      3:       return '0;
      4:       return $urandom;
      default: return SCORE_W'($urandom_range(6)) - SCORE_W'(3);
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(7))
      0:       return '0;
      1:       return TAG_ONES;
      2:       return $urandom;
      default: return TAG_W'($urandom_range(4));
    endcase
  endfunction

  function automatic void queue_random_cmds(int n);
    int    r;
    cmd_t  c;
    mode_t m;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 55)      c = CMD_ADD;
      else if (r < 78) c = CMD_REMOVE_MATCH;
      else if (r < 96) c = CMD_REMOVE_POS;
      else             c = CMD_NOP;
      m = ($urandom_range(9) == 0) ? MODE_ANY : mode_t'($urandom_range(2));
      queue_cmd(c, pick_score(), pick_tag(), m,
                $urandom_range(1) ? POS_W'($urandom_range(15)) : POS_W'($urandom_range(3)));
    end
  endfunction

  // Wait until every queued item has gone in and every reply has come back,
  // then give the block time to settle.
  task automatic drain();
    while (cmd_queue.size() != 0 || in_valid || reply_queue.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the capacity register; only ever called once the block is idle
  task automatic write_capacity(logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    shadow_cap  = v;
  endtask

  // Driver: hold a stalled item, otherwise advance or idle at random
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (cmd_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
      cur_cmd  <= cmd_queue.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check replies first (they belong to older items), then
  // predict the reply for an item taken on this edge.
  always @(posedge clk) begin : monitor
    list_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reply_queue.size() == 0) begin
        $error("unexpected result: status %0d count %0d", status, entry_count);
        mismatch_count++;
      end else begin
        want = reply_queue.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatch_count++;
        end
        if (removed_score !== want.score) begin
          $error("removed_score: expected %0d, got %0d", $signed(want.score), removed_score);
          mismatch_count++;
        end
        if (removed_tag !== want.tag) begin
          $error("removed_tag: expected %h, got %h", want.tag, removed_tag);
          mismatch_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          mismatch_count++;
        end
      end
    end
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken)
      reply_queue.push_back(apply_list_cmd(cur_cmd));
  end

  // Watchdog: end the run when work is pending but nothing moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cmd_queue.size() == 0 && !in_valid && reply_queue.size() == 0))
      hung_cycles = 0;
    else
      hung_cycles++;
    if (hung_cycles >= HANG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] cap_steps[8];
    int               n;
    cap_steps = '{CFG_W'(31), CFG_W'(4), CFG_W'(1), CFG_W'(0),
                  CFG_W'(9), CFG_W'(16), CFG_W'(2), CFG_W'(12)};
    for (n = 0; n < MAX_ENTRIES; n++) begin
      shadow_score[n] = '0;
      shadow_tag[n]   = '0;
    end
    send_gap_pct   = 20;
    recv_stall_pct = 83;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty list at the reset capacity: misses, a no-op, ordering of ties
    queue_cmd(CMD_REMOVE_MATCH, '0, '0, MODE_SCORE, '0);
    queue_cmd(CMD_REMOVE_POS, '0, '0, MODE_SCORE, '0);
    queue_cmd(CMD_NOP, '1, TAG_ONES, MODE_ANY, '1);
    queue_cmd(CMD_ADD, SCORE_HIGHEST, TAG_ONES, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, SCORE_LOWEST, '0, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, '0, 32'd1, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, '0, 32'd2, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, '1, 32'd3, MODE_SCORE, '0);
    queue_cmd(CMD_REMOVE_MATCH, '0, 32'd9, MODE_SCORE, '0);
    queue_cmd(CMD_REMOVE_MATCH, '0, 32'd3, MODE_TAG, '0);
    queue_cmd(CMD_REMOVE_MATCH, '0, 32'd7, MODE_BOTH, '0);
    queue_cmd(CMD_REMOVE_MATCH, '0, 32'd2, MODE_BOTH, '0);
    queue_cmd(CMD_REMOVE_MATCH, 32'd5, 32'd5, MODE_ANY, '0);
    queue_cmd(CMD_REMOVE_POS, '0, '0, MODE_SCORE, POS_W'(15));
    queue_cmd(CMD_REMOVE_POS, '0, '0, MODE_SCORE, '0);

    // Small capacity: refuse below the last entry, push it out on a tie
    write_capacity(CFG_W'(2));
    queue_cmd(CMD_ADD, 32'd10, 32'd10, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, 32'd5, 32'd5, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, 32'd4, 32'd4, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, 32'd5, 32'd6, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, 32'd20, 32'd20, MODE_SCORE, '0);

    // Capacity zero (acts as one) while two entries are held
    write_capacity('0);
    queue_cmd(CMD_ADD, 32'd1, 32'd1, MODE_SCORE, '0);
    queue_cmd(CMD_ADD, 32'd30, 32'd30, MODE_SCORE, '0);
    queue_cmd(CMD_REMOVE_POS, '0, '0, MODE_SCORE, POS_W'(1));
    queue_cmd(CMD_ADD, SCORE_LOWEST, '1, MODE_SCORE, '0);

    // Random part: walk through capacities and idle/stall patterns
    for (n = 0; n < 8; n++) begin
      write_capacity(cap_steps[n]);
      if (n < 3) begin
        send_gap_pct   = 20;
        recv_stall_pct = 83;
      end else if (n < 6) begin
        send_gap_pct   = 83;
        recv_stall_pct = 20;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      queue_random_cmds(ITEMS_PER_SET);
    end

    drain();
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tksl_pkg.sv
rtl/tksl_cell.sv
rtl/top_k_sorted_score_list_top.sv
sim/tb_top.sv
